/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define AST_HOLDS(lbl, clk, rst_n, prop)
`define AST_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/dlkg_pkg.sv */
package dlkg_pkg;

    localparam int TIME_W    = 20;
    localparam int FRAC_W    = 16;
    localparam int RATIO_W   = 16;
    localparam int OVER_W    = 8;
    localparam int UNDER_W   = 12;
    localparam int LEVEL_W   = 3;
    localparam int FLOOR_W   = 2;
    localparam int DEN_W     = FRAC_W + TIME_W;      // target in Q0.16 * us
    localparam int NUM_SHIFT = 28;                   // Q0.16 * Q4.12
    localparam int PROD_W    = RATIO_W + DEN_W;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = 3'd5;
    localparam logic [FLOOR_W-1:0] FLOOR_ON  = 2'd2;

    localparam logic [FRAC_W-1:0]  RST_DEC_SHARE    = 16'd52429;
    localparam logic [RATIO_W-1:0] RST_HARD_THR     = 16'd6144;
    localparam logic [RATIO_W-1:0] RST_OVER_THR     = 16'd4096;
    localparam logic [RATIO_W-1:0] RST_UNDER_THR    = 16'd2867;
    localparam logic [OVER_W-1:0]  RST_OVER_NEEDED  = 8'd3;
    localparam logic [UNDER_W-1:0] RST_UNDER_NEEDED = 12'd180;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_LIMIT  = 3'd5;

    typedef enum logic [2:0] {
        REG_DEC_SHARE    = 3'd0,
        REG_HARD_THR     = 3'd1,
        REG_OVER_THR     = 3'd2,
        REG_UNDER_THR    = 3'd3,
        REG_OVER_NEEDED  = 3'd4,
        REG_UNDER_NEEDED = 3'd5,
        REG_LEVEL_LIMIT  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [FRAC_W-1:0]  dec_share;
        logic [RATIO_W-1:0] hard_thr;
        logic [RATIO_W-1:0] over_thr;
        logic [RATIO_W-1:0] under_thr;
        logic [OVER_W-1:0]  over_frames_needed;
        logic [UNDER_W-1:0] under_frames_needed;
        logic [LEVEL_W-1:0] level_limit;
    } t_cfg;

    // frame class handed from front to back
    typedef enum logic [2:0] {
        CLS_PANIC,
        CLS_OVER,
        CLS_UNDER,
        CLS_HOLD,
        CLS_MISS_HOLD
    } t_cls;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_CMP,
        F_PUSH
    } t_fstate;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/dlkg_ifs.sv */
interface dlkg_in_if import dlkg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  decode_time;
    logic [TIME_W-1:0]  period_time;
    logic               missed;

    modport source (output valid, decode_time, period_time, missed, input ready);
    modport sink   (input valid, decode_time, period_time, missed, output ready);
endinterface

interface dlkg_out_if import dlkg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               drop_c_enh;
    logic               c_base_only;
    logic               fovea_shrunk;
    logic               drop_b_enh;
    logic               low_refresh;
    logic [FLOOR_W-1:0] floor_c;
    logic               c_dc_plane;
    logic [FLOOR_W-1:0] floor_b;

    modport source (output valid, level, drop_c_enh, c_base_only, fovea_shrunk,
                    drop_b_enh, low_refresh, floor_c, c_dc_plane, floor_b,
                    input ready);
    modport sink   (input valid, level, drop_c_enh, c_base_only, fovea_shrunk,
                    drop_b_enh, low_refresh, floor_c, c_dc_plane, floor_b,
                    output ready);
endinterface

/* rtl/dlkg_regs.sv */
module dlkg_regs import dlkg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dec_share           <= RST_DEC_SHARE;
            r_cfg.hard_thr            <= RST_HARD_THR;
            r_cfg.over_thr            <= RST_OVER_THR;
            r_cfg.under_thr           <= RST_UNDER_THR;
            r_cfg.over_frames_needed  <= RST_OVER_NEEDED;
            r_cfg.under_frames_needed <= RST_UNDER_NEEDED;
            r_cfg.level_limit         <= RST_LEVEL_LIMIT;
        end else if (wr_en) begin
            unique case (idx)
                REG_DEC_SHARE:    r_cfg.dec_share           <= pwdata[FRAC_W-1:0];
                REG_HARD_THR:     r_cfg.hard_thr            <= pwdata[RATIO_W-1:0];
                REG_OVER_THR:     r_cfg.over_thr            <= pwdata[RATIO_W-1:0];
                REG_UNDER_THR:    r_cfg.under_thr           <= pwdata[RATIO_W-1:0];
                REG_OVER_NEEDED:  r_cfg.over_frames_needed  <= pwdata[OVER_W-1:0];
                REG_UNDER_NEEDED: r_cfg.under_frames_needed <= pwdata[UNDER_W-1:0];
                REG_LEVEL_LIMIT:  r_cfg.level_limit         <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DEC_SHARE:    prdata = APB_DW'(r_cfg.dec_share);
            REG_HARD_THR:     prdata = APB_DW'(r_cfg.hard_thr);
            REG_OVER_THR:     prdata = APB_DW'(r_cfg.over_thr);
            REG_UNDER_THR:    prdata = APB_DW'(r_cfg.under_thr);
            REG_OVER_NEEDED:  prdata = APB_DW'(r_cfg.over_frames_needed);
            REG_UNDER_NEEDED: prdata = APB_DW'(r_cfg.under_frames_needed);
            REG_LEVEL_LIMIT:  prdata = APB_DW'(r_cfg.level_limit);
            default:          prdata = '0;
        endcase
    end

endmodule

/* rtl/dlkg_front.sv */
module dlkg_front import dlkg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dlkg_in_if.sink i_frame,
    input  t_cfg    i_cfg,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_cls    o_cls
);

    t_fstate             r_state, n_state;
    logic [TIME_W-1:0]   r_decode;
    logic [TIME_W-1:0]   r_period;
    logic                r_miss;
    logic [DEN_W-1:0]    r_den;
    t_cls                r_cls, n_cls;

    logic [PROD_W-1:0]   num;
    logic [PROD_W-1:0]   lim_panic, lim_down, lim_up;
    logic                den_zero;
    logic                ge_panic, gt_down, ge_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid && i_frame.ready) begin
            r_decode <= i_frame.decode_time;
            r_period <= i_frame.period_time;
            r_miss   <= i_frame.missed;
        end
        if (r_state == F_MUL) begin
            r_den <= DEN_W'(i_cfg.dec_share) * DEN_W'(r_period);
        end
        if (r_state == F_CMP) begin
            r_cls <= n_cls;
        end
    end

    // ratio >= r  <=>  decode << 28 >= r * target
    assign num       = PROD_W'({r_decode, {NUM_SHIFT{1'b0}}});
    assign lim_panic = PROD_W'(i_cfg.hard_thr) * PROD_W'(r_den);
    assign lim_down  = PROD_W'(i_cfg.over_thr) * PROD_W'(r_den);
    assign lim_up    = PROD_W'(i_cfg.under_thr) * PROD_W'(r_den);
    assign den_zero  = (r_den == '0);

    always_comb begin
        // zero target means ratio zero
        if (den_zero) begin
            ge_panic = (i_cfg.hard_thr == '0);
            gt_down  = 1'b0;
            ge_up    = (i_cfg.under_thr == '0);
        end else begin
            ge_panic = (num >= lim_panic);
            gt_down  = (num > lim_down);
            ge_up    = (num >= lim_up);
        end
        priority if (ge_panic) begin
            n_cls = CLS_PANIC;
        end else if (gt_down) begin
            n_cls = CLS_OVER;
        end else if (!ge_up && !r_miss) begin
            n_cls = CLS_UNDER;
        end else if (r_miss) begin
            n_cls = CLS_MISS_HOLD;
        end else begin
            n_cls = CLS_HOLD;
        end
    end

    always_comb begin
        n_state       = r_state;
        i_frame.ready = 1'b0;
        o_push        = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                i_frame.ready = 1'b1;
                if (i_frame.valid) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: n_state = F_CMP;
            F_CMP: n_state = F_PUSH;
            F_PUSH: begin
                o_push = !i_q_stat.full;
                if (!i_q_stat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_cls = r_cls;

endmodule

/* rtl/dlkg_queue.sv */
`include "assert_macros.svh"

module dlkg_queue import dlkg_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cls    i_data,
    input  logic    i_pop,
    output t_cls    o_data,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    `AST_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full)
    `AST_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_stat.empty)
    `AST_HOLDS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))

endmodule

/* rtl/dlkg_back.sv */
`include "assert_macros.svh"

module dlkg_back import dlkg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_stat   i_q_stat,
    input  t_cls      i_cls,
    output logic      o_pop,
    dlkg_out_if.source o_knob
);

    logic [LEVEL_W-1:0] r_knob, n_knob;
    logic [OVER_W-1:0]  r_over_cnt, n_over_cnt;
    logic [UNDER_W-1:0] r_under_cnt, n_under_cnt;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level;

    logic [LEVEL_W-1:0] limit;
    logic [OVER_W-1:0]  need_over;
    logic [UNDER_W-1:0] need_under;
    logic [OVER_W:0]    over_inc;
    logic [UNDER_W:0]   under_inc;
    logic               can_raise, can_lower;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || o_knob.ready);

    assign limit      = (i_cfg.level_limit > TOP_LEVEL) ? TOP_LEVEL : i_cfg.level_limit;
    assign need_over  = (i_cfg.over_frames_needed == '0) ? OVER_W'(1)
                                                         : i_cfg.over_frames_needed;
    assign need_under = (i_cfg.under_frames_needed == '0) ? UNDER_W'(1)
                                                          : i_cfg.under_frames_needed;
    assign over_inc   = {1'b0, r_over_cnt} + 1'b1;
    assign under_inc  = {1'b0, r_under_cnt} + 1'b1;
    assign can_raise  = (r_knob < limit);
    assign can_lower  = (r_knob != '0);

    always_comb begin
        n_knob      = r_knob;
        n_over_cnt  = r_over_cnt;
        n_under_cnt = r_under_cnt;
        unique case (i_cls)
            CLS_PANIC: begin
                if (can_raise) begin
                    n_knob = r_knob + 1'b1;
                end
                n_over_cnt  = '0;
                n_under_cnt = '0;
            end
            CLS_OVER: begin
                n_under_cnt = '0;
                if (over_inc >= {1'b0, need_over}) begin
                    n_over_cnt = '0;
                    if (can_raise) begin
                        n_knob = r_knob + 1'b1;
                    end
                end else begin
                    n_over_cnt = over_inc[OVER_W-1:0];
                end
            end
            CLS_UNDER: begin
                n_over_cnt = '0;
                if (under_inc >= {1'b0, need_under}) begin
                    n_under_cnt = '0;
                    if (can_lower) begin
                        n_knob = r_knob - 1'b1;
                    end
                end else begin
                    n_under_cnt = under_inc[UNDER_W-1:0];
                end
            end
            CLS_MISS_HOLD: begin
                n_over_cnt  = '0;
                n_under_cnt = '0;
            end
            CLS_HOLD: n_over_cnt = '0;
            default: ;
        endcase
        // any level change restarts both runs
        if (n_knob != r_knob) begin
            n_over_cnt  = '0;
            n_under_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob      <= '0;
            r_over_cnt  <= '0;
            r_under_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_knob      <= n_knob;
                r_over_cnt  <= n_over_cnt;
                r_under_cnt <= n_under_cnt;
                r_out_valid <= 1'b1;
            end else if (o_knob.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_level <= n_knob;
        end
    end

    assign o_knob.valid        = r_out_valid;
    assign o_knob.level        = r_level;
    assign o_knob.drop_c_enh   = (r_level >= LEVEL_W'(1));
    assign o_knob.c_base_only  = (r_level >= LEVEL_W'(2));
    assign o_knob.fovea_shrunk = (r_level >= LEVEL_W'(3));
    assign o_knob.drop_b_enh   = (r_level >= LEVEL_W'(4));
    assign o_knob.low_refresh  = (r_level >= TOP_LEVEL);
    assign o_knob.floor_c      = (r_level >= LEVEL_W'(1)) ? FLOOR_ON : '0;
    assign o_knob.c_dc_plane   = (r_level >= LEVEL_W'(2));
    assign o_knob.floor_b      = (r_level >= LEVEL_W'(4)) ? FLOOR_ON : '0;

    `AST_HOLDS(a_knob_range, i_clk, i_rst_n, r_knob <= TOP_LEVEL)
    `AST_IMPL(a_change_clears, i_clk, i_rst_n, r_knob != $past(r_knob), r_over_cnt == '0 && r_under_cnt == '0)
    `AST_IMPL(a_out_tracks_knob, i_clk, i_rst_n, r_out_valid, r_level == r_knob)

endmodule

/* rtl/decode_load_knob_governor.sv */
// Channel   Dir  Handshake     Payload
// i_frame   in   valid/ready   decode_time[19:0], period_time[19:0], missed
// o_knob    out  valid/ready   level[2:0], knob flags, floor_c[1:0], floor_b[1:0]
// APB       in   psel/penable  paddr[4:0], pwdata/prdata[31:0], pready tied high
//
// Front takes one item at a time through its four-state sequence (capture, target
// multiply, threshold multiply/compare, push); no new item is taken until the push.
// The push waits while the queue is full; the back registers the result when it pops.
// Queue of QUEUE_DEPTH classified frames lets front and back stall separately.
// Synchronous active-low reset loads register defaults and clears level and run counts.
module decode_load_knob_governor import dlkg_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dlkg_in_if.sink           i_frame,
    dlkg_out_if.source        o_knob,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_q_stat q_stat;
    logic    push, pop;
    t_cls    push_cls, pop_cls;

    dlkg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dlkg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (i_frame),
        .i_cfg    (cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cls    (push_cls)
    );

    dlkg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cls),
        .i_pop   (pop),
        .o_data  (pop_cls),
        .o_stat  (q_stat)
    );

    dlkg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_stat (q_stat),
        .i_cls    (pop_cls),
        .o_pop    (pop),
        .o_knob   (o_knob)
    );

endmodule

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    import dlkg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS    = 5;
    localparam int TIMEOUT_NS     = 10_000_000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_ITEMS    = 235;
    localparam int NUM_PHASES     = 8;
    localparam int LONG_HOLD      = 90;
    localparam logic [APB_AW-1:0] UNUSED_ADDR = 5'd28;   // register index 7, no register

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               drop_c_enh;
        logic               c_base_only;
        logic               fovea_shrunk;
        logic               drop_b_enh;
        logic               low_refresh;
        logic [FLOOR_W-1:0] floor_c;
        logic               c_dc_plane;
        logic [FLOOR_W-1:0] floor_b;
    } t_knob_word;

    typedef enum int {
        FR_PANIC,
        FR_OVER,
        FR_BAND,
        FR_UNDER,
        FR_MISS,
        FR_NOISE
    } t_frame_kind;

    // Governor model: register copy, level and run counts, queue of expected knob words.
    class knob_scoreboard;
        logic [FRAC_W-1:0]  tf;
        logic [RATIO_W-1:0] panic_r;
        logic [RATIO_W-1:0] down_r;
        logic [RATIO_W-1:0] up_r;
        logic [OVER_W-1:0]  over_need;
        logic [UNDER_W-1:0] under_need;
        logic [LEVEL_W-1:0] limit;
        logic [LEVEL_W-1:0] level;
        logic [OVER_W-1:0]  over_cnt;
        logic [UNDER_W-1:0] under_cnt;
        t_knob_word         knob_q[$];
        int                 errors;
        int                 n_checked;

        function new();
            tf         = RST_DEC_SHARE;
            panic_r    = RST_HARD_THR;
            down_r     = RST_OVER_THR;
            up_r       = RST_UNDER_THR;
            over_need  = RST_OVER_NEEDED;
            under_need = RST_UNDER_NEEDED;
            limit      = RST_LEVEL_LIMIT;
            level      = '0;
            over_cnt   = '0;
            under_cnt  = '0;
            errors     = 0;
            n_checked  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_DEC_SHARE:    tf         = v[FRAC_W-1:0];
                REG_HARD_THR:     panic_r    = v[RATIO_W-1:0];
                REG_OVER_THR:     down_r     = v[RATIO_W-1:0];
                REG_UNDER_THR:    up_r       = v[RATIO_W-1:0];
                REG_OVER_NEEDED:  over_need  = v[OVER_W-1:0];
                REG_UNDER_NEEDED: under_need = v[UNDER_W-1:0];
                REG_LEVEL_LIMIT:  limit      = v[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(t_reg_idx idx);
            case (idx)
                REG_DEC_SHARE:    return 32'(tf);
                REG_HARD_THR:     return 32'(panic_r);
                REG_OVER_THR:     return 32'(down_r);
                REG_UNDER_THR:    return 32'(up_r);
                REG_OVER_NEEDED:  return 32'(over_need);
                REG_UNDER_NEEDED: return 32'(under_need);
                REG_LEVEL_LIMIT:  return 32'(limit);
                default:          return '0;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return knob_q.size();
        endfunction

        // classify one frame, step level and counts, queue the knob word
        function void note_frame(logic [TIME_W-1:0] d, logic [TIME_W-1:0] p, logic m);
            logic [63:0]        num;
            logic [63:0]        den;
            logic [LEVEL_W-1:0] lim;
            int                 n_over;
            int                 n_under;
            int                 oc;
            int                 uc;
            bit                 changed;
            t_knob_word         w;

            num     = 64'(d) << NUM_SHIFT;
            den     = 64'(tf) * 64'(p);
            lim     = (limit > TOP_LEVEL) ? TOP_LEVEL : limit;
            n_over  = (over_need == 0) ? 1 : int'(over_need);
            n_under = (under_need == 0) ? 1 : int'(under_need);
            oc      = int'(over_cnt);
            uc      = int'(under_cnt);
            changed = 1'b0;
            if (den == 0) begin
                num = '0;
                den = 64'd1;
            end

            if (num >= 64'(panic_r) * den) begin
                if (level < lim) begin
                    level++;
                    changed = 1'b1;
                end
                oc = 0;
                uc = 0;
            end else if (num > 64'(down_r) * den) begin
                oc++;
                uc = 0;
                if (oc >= n_over) begin
                    if (level < lim) begin
                        level++;
                        changed = 1'b1;
                    end
                    oc = 0;
                end
            end else if (!(num >= 64'(up_r) * den) && !m) begin
                oc = 0;
                uc++;
                if (uc >= n_under) begin
                    if (level > 0) begin
                        level--;
                        changed = 1'b1;
                    end
                    uc = 0;
                end
            end else begin
                oc = 0;
                if (m) uc = 0;
            end
            if (changed) begin
                oc = 0;
                uc = 0;
            end
            over_cnt  = oc[OVER_W-1:0];
            under_cnt = uc[UNDER_W-1:0];

            w.level        = level;
            w.drop_c_enh   = (level >= 1);
            w.c_base_only  = (level >= 2);
            w.fovea_shrunk = (level >= 3);
            w.drop_b_enh   = (level >= 4);
            w.low_refresh  = (level >= 5);
            w.floor_c      = (level >= 1) ? FLOOR_ON : '0;
            w.c_dc_plane   = (level >= 2);
            w.floor_b      = (level >= 4) ? FLOOR_ON : '0;
            knob_q.push_back(w);
        endfunction

        task cmp_field(string name, int got, int exp);
            if (got != exp)
                report_mismatch($sformatf("knob word %0d: %s = %0d, expected %0d",
                                          n_checked, name, got, exp));
        endtask

        task check_result(t_knob_word got);
            t_knob_word exp;
            if (knob_q.size() == 0) begin
                report_mismatch($sformatf("knob word %0d arrived with no frame pending",
                                          n_checked));
            end else begin
                exp = knob_q.pop_front();
                cmp_field("level",        got.level,        exp.level);
                cmp_field("drop_c_enh",   got.drop_c_enh,   exp.drop_c_enh);
                cmp_field("c_base_only",  got.c_base_only,  exp.c_base_only);
                cmp_field("fovea_shrunk", got.fovea_shrunk, exp.fovea_shrunk);
                cmp_field("drop_b_enh",   got.drop_b_enh,   exp.drop_b_enh);
                cmp_field("low_refresh",  got.low_refresh,  exp.low_refresh);
                cmp_field("floor_c",      got.floor_c,      exp.floor_c);
                cmp_field("c_dc_plane",   got.c_dc_plane,   exp.c_dc_plane);
                cmp_field("floor_b",      got.floor_b,      exp.floor_b);
            end
            n_checked++;
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    dlkg_in_if  frame_if ();
    dlkg_out_if knob_if ();

    knob_scoreboard sb;
    bit burst_in;
    bit burst_out;
    int hold_len;

    decode_load_knob_governor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_if),
        .o_knob  (knob_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF_NS;
        i_clk = 1'b1;
        #CLK_HALF_NS;
    end

    initial begin
        #TIMEOUT_NS;
        $display("TB_ERROR");
        $finish;
    end

    // output first: a knob word can never belong to a frame taken on the same edge
    always @(posedge i_clk) begin
        t_knob_word got;
        if (i_rst_n) begin
            if (knob_if.valid && knob_if.ready) begin
                got.level        = knob_if.level;
                got.drop_c_enh   = knob_if.drop_c_enh;
                got.c_base_only  = knob_if.c_base_only;
                got.fovea_shrunk = knob_if.fovea_shrunk;
                got.drop_b_enh   = knob_if.drop_b_enh;
                got.low_refresh  = knob_if.low_refresh;
                got.floor_c      = knob_if.floor_c;
                got.c_dc_plane   = knob_if.c_dc_plane;
                got.floor_b      = knob_if.floor_b;
                sb.check_result(got);
            end
            if (frame_if.valid && frame_if.ready)
                sb.note_frame(frame_if.decode_time, frame_if.period_time, frame_if.missed);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // knob word sink: random stalls, plus one long hold when asked
    initial begin
        int n;
        knob_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                knob_if.ready <= 1'b0;
                n = hold_len;
                hold_len = 0;
                repeat (n - 1) @(negedge i_clk);
            end else if (!burst_out && $urandom_range(0, 3) == 0) begin
                knob_if.ready <= 1'b0;
                n = pick_gap();
                if (n == 0) n = 1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                knob_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_frame(input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] p,
                              input logic m);
        int gap;
        gap = burst_in ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        frame_if.valid       <= 1'b1;
        frame_if.decode_time <= d;
        frame_if.period_time <= p;
        frame_if.missed      <= m;
        do @(posedge i_clk); while (!frame_if.ready);
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        frame_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] v);
        apb_write({idx, 2'b00}, v);
        sb.set_reg(idx, v);
    endtask

    task automatic cfg_readback();
        t_reg_idx    idx;
        logic [31:0] got;
        for (int i = 0; i <= int'(REG_LEVEL_LIMIT); i++) begin
            idx = t_reg_idx'(i);
            @(negedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            got = prdata;
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            if (got !== sb.reg_value(idx))
                sb.report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                             idx.name(), got, sb.reg_value(idx)));
        end
    endtask

    task automatic load_regs(input logic [31:0] tf, input logic [31:0] pr,
                             input logic [31:0] dr, input logic [31:0] ur,
                             input logic [31:0] on, input logic [31:0] un,
                             input logic [31:0] lim);
        cfg_write(REG_DEC_SHARE,    tf);
        cfg_write(REG_HARD_THR,     pr);
        cfg_write(REG_OVER_THR,     dr);
        cfg_write(REG_UNDER_THR,    ur);
        cfg_write(REG_OVER_NEEDED,  on);
        cfg_write(REG_UNDER_NEEDED, un);
        cfg_write(REG_LEVEL_LIMIT,  lim);
        apb_write(UNUSED_ADDR, $urandom);   // no register there, must change nothing
        cfg_readback();
    endtask

    // Pick a ratio inside the band of the wanted class and back out the decode
    // time from the current target; a quarter of the time land right on the edge.
    task automatic make_frame(input t_frame_kind kind, output logic [TIME_W-1:0] d,
                              output logic [TIME_W-1:0] p, output logic m);
        int          lo;
        int          hi;
        int          r;
        int          delta;
        logic [63:0] den;
        logic [63:0] q;
        case ($urandom_range(0, 15))
            0:       p = '0;
            1:       p = '1;
            2, 3:    p = 20'd8192;
            4:       p = TIME_W'($urandom);
            default: p = TIME_W'($urandom_range(1000, 70000));
        endcase
        den = 64'(sb.tf) * 64'(p);
        m   = ($urandom_range(0, 15) == 0);
        lo  = 0;
        hi  = 0;
        case (kind)
            FR_PANIC: begin
                lo = int'(sb.panic_r);
                hi = lo + 4096;
            end
            FR_OVER: begin
                lo = int'(sb.down_r) + 1;
                hi = int'(sb.panic_r) - 1;
            end
            FR_BAND: begin
                lo = int'(sb.up_r);
                hi = int'(sb.down_r);
            end
            FR_UNDER: begin
                lo = 0;
                hi = int'(sb.up_r) - 1;
            end
            FR_MISS: begin
                lo = 0;
                hi = int'(sb.panic_r) + 1024;
                m  = 1'b1;
            end
            default: begin
                lo = 1;
                hi = 0;
                m  = $urandom_range(0, 1);
            end
        endcase
        if (den == 0 || lo > hi) begin
            d = TIME_W'($urandom);
        end else begin
            r = $urandom_range(lo, hi);
            if ($urandom_range(0, 3) == 0) begin
                q     = (64'(r) * den) >> NUM_SHIFT;
                delta = $urandom_range(0, 2);
                if (delta == 0 && q != 0) q = q - 1;
                else if (delta == 2) q = q + 1;
            end else begin
                q = (64'(r) * den + 64'($urandom_range(0, (1 << NUM_SHIFT) - 1))) >> NUM_SHIFT;
            end
            if (q > 64'hFFFFF) q = 64'hFFFFF;
            d = q[TIME_W-1:0];
        end
    endtask

    // mostly runs of one class, long enough to trip the run counts
    task automatic random_frames(input int n_items);
        int          sent;
        int          len;
        int          r;
        int          need;
        t_frame_kind kind;
        logic [TIME_W-1:0] d;
        logic [TIME_W-1:0] p;
        logic        m;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 30)      kind = FR_UNDER;
            else if (r < 55) kind = FR_OVER;
            else if (r < 70) kind = FR_BAND;
            else if (r < 80) kind = FR_PANIC;
            else if (r < 88) kind = FR_MISS;
            else             kind = FR_NOISE;
            case (kind)
                FR_OVER: begin
                    need = (sb.over_need == 0) ? 1 : int'(sb.over_need);
                    len  = $urandom_range(1, need + 2);
                end
                FR_UNDER: begin
                    need = (sb.under_need == 0) ? 1 : int'(sb.under_need);
                    len  = $urandom_range(1, need + 2);
                    if (len > 200) len = 200;
                end
                default: len = $urandom_range(1, 4);
            endcase
            if (len > n_items - sent) len = n_items - sent;
            repeat (len) begin
                make_frame(kind, d, p, m);
                send_frame(d, p, m);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        burst_in  = 1'b0;
        burst_out = 1'b0;
        hold_len  = 0;
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        frame_if.valid       = 1'b0;
        frame_if.decode_time = '0;
        frame_if.period_time = '0;
        frame_if.missed      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        // directed, reset register values
        cfg_readback();
        send_frame(20'd0, 20'd0, 1'b0);             // zero target
        send_frame(20'hFFFFF, 20'd0, 1'b0);         // zero target, max decode
        repeat (3) send_frame(20'd9000, 20'd10000, 1'b0);   // over run raises
        send_frame(20'd9000, 20'd10000, 1'b1);      // over target with miss
        send_frame(20'd7000, 20'd10000, 1'b0);      // dead band
        send_frame(20'd7000, 20'd10000, 1'b1);      // dead band with miss
        send_frame(20'd1000, 20'd10000, 1'b0);      // under target
        send_frame(20'd1000, 20'd10000, 1'b1);      // under but missed
        send_frame(20'd12000, 20'd10000, 1'b0);     // just below panic
        send_frame(20'd12001, 20'd10000, 1'b0);     // just at panic
        repeat (5) send_frame(20'hFFFFF, 20'd1, 1'b0);      // panic up to the top
        send_frame(20'hFFFFF, 20'hFFFFF, 1'b1);
        send_frame(20'd0, 20'hFFFFF, 1'b0);
        send_frame(20'd0, 20'hFFFFF, 1'b1);
        wait_results();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            burst_in  = (ph % 4 == 3);
            burst_out = (ph % 3 == 2);
            case (ph)
                1: load_regs(32768, 6144, 4096, 2867, 1, 2, 5);
                2: load_regs($urandom_range(20000, 65535), $urandom_range(6144, 12288),
                             $urandom_range(2048, 6143), $urandom_range(0, 2047),
                             $urandom_range(1, 4), $urandom_range(1, 6),
                             $urandom_range(4, 5));
                3: load_regs(52429, 6144, 4096, 2867, 0, 0, 7);
                4: load_regs(0, 6144, 4096, 2867, 2, 4, 2);
                5: load_regs(65535, 65535, 65535, 65535, 255, 4095, 0);
                6: load_regs(40000, 0, 0, 0, 3, 3, 3);
                7: load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom);
                default: load_regs(52429, 6144, 4096, 2867, 2, 3, 6);
            endcase
            if (ph == 1) begin
                // sink holds off while frames keep coming, so the block backs up
                random_frames(40);
                burst_in = 1'b1;
                hold_len = LONG_HOLD;
                random_frames(30);
                burst_in = 1'b0;
                random_frames(PHASE_ITEMS - 70);
            end else if (ph == 2) begin
                random_frames(120);
                @(negedge i_clk);
                frame_if.valid <= 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
                random_frames(PHASE_ITEMS - 120);
            end else begin
                random_frames(PHASE_ITEMS);
            end
            wait_results();
        end

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
